// ----- rtl/core/qfft_pkg.sv -----
// Shared widths and stage constants for the quad face front-facing test.
package qfft_pkg;

    // Reduced normal components stay below 2^RED_BITS.
    localparam int RED_BITS  = 30;
    localparam int SQ_BITS   = 2 * RED_BITS;
    localparam int LEN2_BITS = 64;
    localparam int ROOT_STEPS = 32;
    localparam int LEN_BITS  = 31;
    localparam int REM_BITS  = 32;
    // Unit z is Q1.16; its magnitude never exceeds 2^16.
    localparam int UNIT_FRAC = 16;
    localparam int QUO_BITS  = UNIT_FRAC + 1;
    localparam int QZ_BITS   = QUO_BITS + 1;
    localparam int SUM_BITS  = QZ_BITS + 2;

endpackage

// ----- rtl/core/qfft_lane.sv -----
// One corner normal: magnitude reduction, length by square root, unit z by division.
module qfft_lane #(
    parameter int CW = 51
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [CW-1:0]                 nx,
    input  logic signed [CW-1:0]                 ny,
    input  logic signed [CW-1:0]                 nz,
    output logic                                 out_valid,
    output logic                                 out_zero,
    output logic signed [qfft_pkg::QZ_BITS-1:0]  out_qz
);

    localparam int RB = qfft_pkg::RED_BITS;
    localparam int XW = (CW > RB) ? CW : RB;
    localparam int SW = $clog2(XW + 1);
    localparam int NR = qfft_pkg::ROOT_STEPS;
    localparam int NQ = qfft_pkg::QUO_BITS;
    localparam int L2W = qfft_pkg::LEN2_BITS;
    localparam int LW = qfft_pkg::LEN_BITS;
    localparam int MW = qfft_pkg::REM_BITS;

    // front stages: magnitudes, shift search, shift, squares, sum
    logic [3:0]    v_reg;
    logic [CW-1:0] m1x_reg, m1y_reg, m1z_reg;
    logic          s1_reg;
    logic [CW-1:0] m2x_reg, m2y_reg, m2z_reg;
    logic          s2_reg, z2_reg;
    logic [SW-1:0] sh2_reg;
    logic [RB-1:0] r3x_reg, r3y_reg, r3z_reg;
    logic          s3_reg, z3_reg;
    logic [qfft_pkg::SQ_BITS-1:0] q4x_reg, q4y_reg, q4z_reg;
    logic [RB-1:0] mz4_reg;
    logic          s4_reg, z4_reg;

    logic [CW-1:0] orm;
    logic [SW-1:0] sh_next;
    logic [XW-1:0] ex, ey, ez, fx, fy, fz;

    always_comb
    begin
        int hi;
        int sh;
        hi = 0;
        orm = m1x_reg | m1y_reg | m1z_reg;
        for (int i = 0; i < CW; i++)
        begin
            if (orm[i])
                hi = i + 1;
        end
        sh = (hi > RB) ? hi - RB : 0;
        sh_next = SW'(sh);
    end

    always_comb
    begin
        ex = XW'(m2x_reg);
        ey = XW'(m2y_reg);
        ez = XW'(m2z_reg);
        fx = ex >> sh2_reg;
        fy = ey >> sh2_reg;
        fz = ez >> sh2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1x_reg <= nx[CW-1] ? CW'(-nx) : CW'(nx);
            m1y_reg <= ny[CW-1] ? CW'(-ny) : CW'(ny);
            m1z_reg <= nz[CW-1] ? CW'(-nz) : CW'(nz);
            s1_reg  <= nz[CW-1];
            m2x_reg <= m1x_reg;
            m2y_reg <= m1y_reg;
            m2z_reg <= m1z_reg;
            s2_reg  <= s1_reg;
            z2_reg  <= (orm == '0);
            sh2_reg <= sh_next;
            r3x_reg <= fx[RB-1:0];
            r3y_reg <= fy[RB-1:0];
            r3z_reg <= fz[RB-1:0];
            s3_reg  <= s2_reg;
            z3_reg  <= z2_reg;
            q4x_reg <= qfft_pkg::SQ_BITS'(r3x_reg) * qfft_pkg::SQ_BITS'(r3x_reg);
            q4y_reg <= qfft_pkg::SQ_BITS'(r3y_reg) * qfft_pkg::SQ_BITS'(r3y_reg);
            q4z_reg <= qfft_pkg::SQ_BITS'(r3z_reg) * qfft_pkg::SQ_BITS'(r3z_reg);
            mz4_reg <= r3z_reg;
            s4_reg  <= s3_reg;
            z4_reg  <= z3_reg;
        end
    end

    // square root: one result bit per stage
    logic [L2W-1:0] rx_reg [0:NR];
    logic [L2W-1:0] rr_reg [0:NR];
    logic [RB-1:0]  rmz_reg [0:NR];
    logic           rs_reg [0:NR];
    logic           rz_reg [0:NR];
    logic [NR:0]    rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= v_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]  <= L2W'(q4x_reg) + L2W'(q4y_reg) + L2W'(q4z_reg);
            rr_reg[0]  <= '0;
            rmz_reg[0] <= mz4_reg;
            rs_reg[0]  <= s4_reg;
            rz_reg[0]  <= z4_reg;
        end
    end

    for (genvar k = 0; k < NR; k++)
    begin : g_root
        logic [L2W-1:0] bitv, trial;
        assign bitv  = L2W'(1) << (L2W - 2 - 2 * k);
        assign trial = rr_reg[k] + bitv;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[k+1] <= 1'b0;
            else if (en)
                rv_reg[k+1] <= rv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rx_reg[k] >= trial)
                begin
                    rx_reg[k+1] <= rx_reg[k] - trial;
                    rr_reg[k+1] <= (rr_reg[k] >> 1) + bitv;
                end
                else
                begin
                    rx_reg[k+1] <= rx_reg[k];
                    rr_reg[k+1] <= rr_reg[k] >> 1;
                end
                rmz_reg[k+1] <= rmz_reg[k];
                rs_reg[k+1]  <= rs_reg[k];
                rz_reg[k+1]  <= rz_reg[k];
            end
        end
    end

    // restoring division: one quotient bit per stage, high bit first
    logic [MW-1:0] dr_reg [0:NQ];
    logic [LW-1:0] dl_reg [0:NQ];
    logic [NQ-1:0] dq_reg [0:NQ];
    logic          db_reg [0:NQ];
    logic          ds_reg [0:NQ];
    logic          dz_reg [0:NQ];
    logic [NQ:0]   dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= rv_reg[NR];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg[0] <= MW'(rmz_reg[NR] >> 1);
            db_reg[0] <= rmz_reg[NR][0];
            dl_reg[0] <= rr_reg[NR][LW-1:0];
            dq_reg[0] <= '0;
            ds_reg[0] <= rs_reg[NR];
            dz_reg[0] <= rz_reg[NR];
        end
    end

    for (genvar j = 0; j < NQ; j++)
    begin : g_div
        logic [MW-1:0] part, lenx;
        assign part = {dr_reg[j][MW-2:0], (j == 0) ? db_reg[j] : 1'b0};
        assign lenx = MW'(dl_reg[j]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= 1'b0;
            else if (en)
                dv_reg[j+1] <= dv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (part >= lenx)
                begin
                    dr_reg[j+1] <= part - lenx;
                    dq_reg[j+1] <= dq_reg[j] | (NQ'(1) << (NQ - 1 - j));
                end
                else
                begin
                    dr_reg[j+1] <= part;
                    dq_reg[j+1] <= dq_reg[j];
                end
                dl_reg[j+1] <= dl_reg[j];
                db_reg[j+1] <= db_reg[j];
                ds_reg[j+1] <= ds_reg[j];
                dz_reg[j+1] <= dz_reg[j];
            end
        end
    end

    logic signed [qfft_pkg::QZ_BITS-1:0] qz_reg;
    logic signed [qfft_pkg::QZ_BITS-1:0] quo;
    logic                                zo_reg, vo_reg;

    assign quo = signed'(qfft_pkg::QZ_BITS'(dq_reg[NQ]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= dv_reg[NQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qz_reg <= ds_reg[NQ] ? -quo : quo;
            zo_reg <= dz_reg[NQ];
        end
    end

    assign out_valid = vo_reg;
    assign out_zero  = zo_reg;
    assign out_qz    = qz_reg;

    // a nonzero normal always has a length at least its z magnitude
    a_len_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[0] && !dz_reg[0]) |-> (dl_reg[0] != '0))
        else $error("nonzero normal with zero length");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[NQ] && !dz_reg[NQ]) |-> (dr_reg[NQ] < MW'(dl_reg[NQ])))
        else $error("division remainder not below length");
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[NQ] && !dz_reg[NQ]) |-> (dq_reg[NQ] <= (NQ'(1) << (NQ - 1))))
        else $error("unit z above one");

endmodule

// ----- rtl/core/quad_face_front_facing_test_top.sv -----
// Top level of the quad face front-facing test: edges, corner normals, lanes, sum, output skid.
//
//   channel | signals                                   | dir | meaning
//   in      | in_valid in_ready corner_{a..d}_{x,y,z}   | in  | one quad face per beat
//   out     | out_valid out_ready front_facing degenerate| out | one verdict per face
//
// Takes one face per cycle while in_ready is high; each of the four parallel normal lanes
// holds a 32-stage square root and a 17-stage divider.
// Reset clears all valid bits; the data registers have no reset.
// A stalled output beat fills a one-beat skid; only then does in_ready drop and the
// whole pipeline hold, losing nothing.
module quad_face_front_facing_test_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] corner_a_x,
    input  logic signed [COORD_BITS-1:0] corner_a_y,
    input  logic signed [COORD_BITS-1:0] corner_a_z,
    input  logic signed [COORD_BITS-1:0] corner_b_x,
    input  logic signed [COORD_BITS-1:0] corner_b_y,
    input  logic signed [COORD_BITS-1:0] corner_b_z,
    input  logic signed [COORD_BITS-1:0] corner_c_x,
    input  logic signed [COORD_BITS-1:0] corner_c_y,
    input  logic signed [COORD_BITS-1:0] corner_c_z,
    input  logic signed [COORD_BITS-1:0] corner_d_x,
    input  logic signed [COORD_BITS-1:0] corner_d_y,
    input  logic signed [COORD_BITS-1:0] corner_d_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         front_facing,
    output logic                         degenerate
);

    localparam int DW = COORD_BITS + 1;
    localparam int ES = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int EW = DW - ES;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int QW = qfft_pkg::QZ_BITS;
    localparam int SMW = qfft_pkg::SUM_BITS;

    logic en;
    logic skid_v_reg, out_v_reg;
    logic skid_ff_reg, skid_dg_reg, out_ff_reg, out_dg_reg;

    assign en = !skid_v_reg;
    assign in_ready = en;

    // stage 0: capture corners
    logic signed [COORD_BITS-1:0] p_in [0:3][0:2];
    logic signed [COORD_BITS-1:0] p_reg [0:3][0:2];
    logic v0_reg, v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        p_in[0][0] = corner_a_x; p_in[0][1] = corner_a_y; p_in[0][2] = corner_a_z;
        p_in[1][0] = corner_b_x; p_in[1][1] = corner_b_y; p_in[1][2] = corner_b_z;
        p_in[2][0] = corner_c_x; p_in[2][1] = corner_c_y; p_in[2][2] = corner_c_z;
        p_in[3][0] = corner_d_x; p_in[3][1] = corner_d_y; p_in[3][2] = corner_d_z;
    end

    // stage 1: edges, truncated toward zero when wide
    logic signed [EW-1:0] e_next [0:3][0:2];
    logic signed [EW-1:0] e_reg [0:3][0:2];

    always_comb
    begin
        logic signed [DW-1:0] d;
        logic [DW-1:0] m;
        logic [DW-1:0] t;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d = DW'(p_reg[(k + 1) % 4][i]) - DW'(p_reg[k][i]);
                m = d[DW-1] ? DW'(-d) : DW'(d);
                t = m >> ES;
                e_next[k][i] = d[DW-1] ? -signed'(t[EW-1:0]) : signed'(t[EW-1:0]);
            end
        end
    end

    // stage 2: cross product terms; stage 3: differences
    logic signed [PW-1:0] pa_reg [0:3][0:2];
    logic signed [PW-1:0] pb_reg [0:3][0:2];
    logic signed [CW-1:0] n_reg [0:3][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[k][i] <= p_in[k][i];
                    e_reg[k][i] <= e_next[k][i];
                    n_reg[k][i] <= CW'(pa_reg[k][i]) - CW'(pb_reg[k][i]);
                end
                // u = previous edge, w = this edge
                pa_reg[k][0] <= PW'(e_reg[(k + 3) % 4][1]) * PW'(e_reg[k][2]);
                pb_reg[k][0] <= PW'(e_reg[(k + 3) % 4][2]) * PW'(e_reg[k][1]);
                pa_reg[k][1] <= PW'(e_reg[(k + 3) % 4][2]) * PW'(e_reg[k][0]);
                pb_reg[k][1] <= PW'(e_reg[(k + 3) % 4][0]) * PW'(e_reg[k][2]);
                pa_reg[k][2] <= PW'(e_reg[(k + 3) % 4][0]) * PW'(e_reg[k][1]);
                pb_reg[k][2] <= PW'(e_reg[(k + 3) % 4][1]) * PW'(e_reg[k][0]);
            end
        end
    end

    logic [3:0]             lv, lz;
    logic signed [QW-1:0]   lq [0:3];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        qfft_lane #(.CW(CW)) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v3_reg),
            .nx        (n_reg[k][0]),
            .ny        (n_reg[k][1]),
            .nz        (n_reg[k][2]),
            .out_valid (lv[k]),
            .out_zero  (lz[k]),
            .out_qz    (lq[k])
        );
    end

    // final stage: sum of unit z values
    logic signed [SMW-1:0] sum;
    logic res_v_reg, res_ff_reg, res_dg_reg;

    assign sum = SMW'(lq[0]) + SMW'(lq[1]) + SMW'(lq[2]) + SMW'(lq[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else if (en)
            res_v_reg <= &lv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_dg_reg <= |lz;
            res_ff_reg <= !(|lz) && (sum > 0);
        end
    end

    // output register with one-beat skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
        begin
            out_v_reg  <= skid_v_reg || (en && res_v_reg);
            skid_v_reg <= 1'b0;
        end
        else if (en && res_v_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
        begin
            out_ff_reg <= skid_v_reg ? skid_ff_reg : res_ff_reg;
            out_dg_reg <= skid_v_reg ? skid_dg_reg : res_dg_reg;
        end
        else if (en && res_v_reg)
        begin
            skid_ff_reg <= res_ff_reg;
            skid_dg_reg <= res_dg_reg;
        end
    end

    assign out_valid    = out_v_reg;
    assign front_facing = out_ff_reg;
    assign degenerate   = out_dg_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a beat while output is empty");
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !out_ready))
        else $error("skid filled without an output stall");
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> !(out_ff_reg && out_dg_reg))
        else $error("degenerate face reported front-facing");
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lv == 4'b0000) || (lv == 4'b1111))
        else $error("normal lanes out of step");

endmodule
